FILE: hdl/rie_pkg.sv
// shared types and format codes for the immediate extract and deposit unit
package rie_pkg;

	// format selector carried in tuser
	typedef enum logic [3:0] {
		OP_SR3   = 4'd0,
		OP_LD5   = 4'd1,
		OP_ST5   = 4'd2,
		OP_BRK5  = 4'd3,
		OP_SM5   = 4'd4,
		OP_IM11  = 4'd5,
		OP_IM14  = 4'd6,
		OP_IM21  = 4'd7,
		OP_BR12  = 4'd8,
		OP_BR17  = 4'd9,
		OP_DEP14 = 4'd10,
		OP_DEP21 = 4'd11
	} rie_op_t;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned OP_W   = 4;

	typedef logic [WORD_W-1:0] rie_word_t;

endpackage

FILE: hdl/rie_field_unit.sv
// combinational field extract and deposit logic for one item
module rie_field_unit (
	input  logic [3:0]  op,
	input  logic [31:0] word,
	input  logic [31:0] operand,
	output logic [31:0] value
);
	import rie_pkg::*;

	rie_op_t   op_e;
	rie_word_t w;
	rie_word_t d;

	assign op_e = rie_op_t'(op);
	assign w    = word;
	assign d    = operand;

	// select the result for the given format
	always_comb begin
		case (op_e)
			OP_SR3:   value = {29'd0, w[13], w[15:14]};
			OP_LD5:   value = {{28{w[16]}}, w[20:17]};
			OP_ST5:   value = {{28{w[0]}}, w[4:1]};
			OP_BRK5:  value = {27'd0, w[4:0]};
			OP_SM5:   value = {27'd0, w[20:16]};
			OP_IM11:  value = {{22{w[0]}}, w[10:1]};
			OP_IM14:  value = {{19{w[0]}}, w[13:1]};
			// scattered left immediate, reassembled then shifted by 11
			OP_IM21:  value = {w[0], w[11:1], w[15:14], w[20:16], w[13:12], 11'd0};
			// scrambled branch displacements, sign from bit 0, scaled by 4
			OP_BR12:  value = {{18{w[0]}}, w[0], w[2], w[12:3], 2'b00};
			OP_BR17:  value = {{13{w[0]}}, w[0], w[20:16], w[2], w[12:3], 2'b00};
			// low-sign 14-bit encoding ored into the word
			OP_DEP14: value = w | {18'd0, d[12:0], 1'b0} | {31'd0, d[31]};
			// scattered 21-bit encoding ored into the word
			OP_DEP21: value = w | {11'd0, d[6:2], d[8:7], d[1:0], d[19:9], d[20]};
			default:  value = '0;
		endcase
	end

endmodule

FILE: hdl/risc_immediate_extract_deposit_unit.sv
// top level: input register, field logic and output register on a stream interface
// path: an accepted item is registered in the input stage, then passes the field logic
// into the output register, from which m_axis presents its result
// throughput: one item per cycle while m_axis_tready is high
// a stalled output holds its result while the input stage keeps one more item
// reset: arst_n clears both stage valid flags asynchronously; payload is not reset
module risc_immediate_extract_deposit_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // word [31:0], operand [63:32]
	input  logic [3:0]  s_axis_tuser,  // op [3:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // value [31:0]
);
	import rie_pkg::*;

	logic        v_s1;
	logic [3:0]  op_s1;
	logic [31:0] word_s1;
	logic [31:0] operand_s1;
	logic        v_s2;
	logic [31:0] value_s2;
	logic [31:0] value_c;
	logic        adv2;
	logic        adv1;
	logic        in_acc;

	// stage advance control
	assign adv2          = !v_s2 || m_axis_tready;
	assign adv1          = !v_s1 || adv2;
	assign s_axis_tready = adv1;
	assign in_acc        = s_axis_tvalid && adv1;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1      <= s_axis_tuser;
			word_s1    <= s_axis_tdata[31:0];
			operand_s1 <= s_axis_tdata[63:32];
		end
	end

	// field logic
	rie_field_unit u_field (
		.op      (op_s1),
		.word    (word_s1),
		.operand (operand_s1),
		.value   (value_c)
	);

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			value_s2 <= value_c;
		end
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = value_s2;

`ifndef SYNTHESIS
	// an accepted item always lands in the input stage
	a_in_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> v_s1)
		else $error("accepted item lost at input stage");

	// a result only appears after the input stage held an item
	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s2) |-> $past(v_s1))
		else $error("result appeared without an item in the input stage");

	// a blocked input stage keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv2) |=> (v_s1 && $stable(word_s1) && $stable(op_s1)))
		else $error("input stage item changed while blocked");
`endif

endmodule
